// ----- rtl/hill3_pkg.sv -----
// Shared types, constants and small lookup functions for the 3x3 Hill cipher block.
// No dependencies; used by hill3_mac and hill_cipher_3x3_mod26_top.
package hill3_pkg;

  localparam int BLOCK_LEN = 3;
  localparam int ALPHA = 26;
  localparam int KEY_W = 45;
  localparam int LETTER_W = 5;

  // 26*26 lies above any product of two reduced letters, so adding it keeps a difference positive.
  localparam int ALPHA_SQ = ALPHA * ALPHA;
  // ceil(2^16 / 26); exact quotient for every sum the accumulator can form.
  localparam int RECIP26 = 2521;
  localparam int RECIP_SHIFT = 16;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [0:0] reg_idx_t;

  localparam reg_idx_t REG_KEY_MATRIX = 1'b0;
  localparam reg_idx_t REG_DECRYPT_MODE = 1'b1;

  localparam letter_t PAD_LETTER = letter_t'(23);

  typedef struct packed {
    logic mul;
    logic acc;
    logic clr;
    logic sub;
  } mac_ctl_t;

  function automatic letter_t red26(input letter_t v);
    red26 = (v >= letter_t'(ALPHA)) ? letter_t'(v - letter_t'(ALPHA)) : v;
  endfunction

  function automatic letter_t inv26(input letter_t d);
    unique case (d)
      5'd1:    inv26 = 5'd1;
      5'd3:    inv26 = 5'd9;
      5'd5:    inv26 = 5'd21;
      5'd7:    inv26 = 5'd15;
      5'd9:    inv26 = 5'd3;
      5'd11:   inv26 = 5'd19;
      5'd15:   inv26 = 5'd7;
      5'd17:   inv26 = 5'd23;
      5'd19:   inv26 = 5'd11;
      5'd21:   inv26 = 5'd5;
      5'd23:   inv26 = 5'd17;
      5'd25:   inv26 = 5'd25;
      default: inv26 = 5'd0;
    endcase
  endfunction

endpackage

// ----- rtl/hill3_mac.sv -----
// Shared multiply-accumulate unit modulo 26: one registered product, then add or subtract.
// Depends on hill3_pkg.
module hill3_mac (
  input  logic               clk,
  input  hill3_pkg::mac_ctl_t ctl,
  input  hill3_pkg::letter_t  op_a,
  input  hill3_pkg::letter_t  op_b,
  output hill3_pkg::letter_t  acc
);
  import hill3_pkg::*;

  logic [9:0]  prod;
  logic [9:0]  base;
  logic [9:0]  addend;
  logic [9:0]  sum;
  logic [20:0] scaled;
  logic [4:0]  quot;
  logic [9:0]  rem;

  always_comb begin
    base   = ctl.clr ? 10'd0 : {5'd0, acc};
    addend = ctl.sub ? 10'(10'(ALPHA_SQ) - prod) : prod;
    sum    = 10'(base + addend);
    scaled = 21'(21'(sum) * 21'(RECIP26));
    quot   = scaled[RECIP_SHIFT +: 5];
    rem    = 10'(sum - 10'(10'(quot) * 10'(ALPHA)));
  end

  always_ff @(posedge clk) begin
    if (ctl.mul) begin
      prod <= 10'(10'(red26(op_a)) * 10'(red26(op_b)));
    end
    if (ctl.acc) begin
      acc <= rem[4:0];
    end
  end

endmodule

// ----- rtl/hill_cipher_3x3_mod26_top.sv -----
// A letter that does not complete a group is stored while the block stays idle. A completed group
// gives each word after three multiply-accumulates plus a store, and the next letter is taken
// once the third word has been accepted at the output. The first group after reset or a
// register write in decrypt mode first computes the inverse key (only the cofactors and the
// determinant when the key has no inverse); encrypt mode adds none. Reset clears the registers,
// group count and key.
module hill_cipher_3x3_mod26_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // letter[4:0], zero fill above
  input  logic                  s_tlast,   // last_letter
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // out_letter[4:0], zero fill above
  output logic                  m_tlast,   // last_of_group
  output logic                  m_tuser,   // key_invalid
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  hill3_pkg::reg_idx_t   cfg_index,
  input  logic [44:0]           cfg_data
);
  import hill3_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_COF, S_DET, S_ADJ, S_MAC, S_OUT} state_t;
  typedef enum logic [1:0] {PH_MUL, PH_ACC, PH_STORE} phase_t;

  localparam logic [1:0] LAST_IDX = 2'(BLOCK_LEN - 1);

  state_t         state;
  phase_t         phase;
  logic [1:0]     row;
  logic [1:0]     col;
  logic [1:0]     term;
  logic [KEY_W-1:0] key_matrix;
  logic           decrypt_mode;
  logic [1:0]     fill_count;
  letter_t        held [2];
  letter_t        grp [3];
  letter_t        cof [3][3];
  letter_t        wk [3][3];
  letter_t        kk [3][3];
  letter_t        inv_reg;
  logic           key_ready;
  logic           key_bad;
  letter_t        out_letter;
  logic           out_last;
  logic           out_bad;
  letter_t        letter;
  letter_t        op_a;
  letter_t        op_b;
  letter_t        acc;
  letter_t        det_inv;
  mac_ctl_t       ctl;
  logic           compute;
  logic [1:0]     last_term;

  function automatic logic [1:0] inc3(input logic [1:0] v);
    inc3 = (v == LAST_IDX) ? 2'd0 : 2'(v + 2'd1);
  endfunction

  function automatic logic [1:0] dec3(input logic [1:0] v);
    dec3 = (v == 2'd0) ? LAST_IDX : 2'(v - 2'd1);
  endfunction

  assign letter    = s_tdata[LETTER_W-1:0];
  assign s_tready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign m_tdata   = {3'd0, out_letter};
  assign m_tlast   = out_last;
  assign m_tuser   = out_bad;
  assign det_inv   = inv26(acc);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        kk[r][c] = red26(key_matrix[LETTER_W*(3*r+c) +: LETTER_W]);
      end
    end
  end

  always_comb begin
    op_a      = '0;
    op_b      = '0;
    compute   = 1'b1;
    last_term = 2'd0;
    unique case (state)
      S_COF: begin
        last_term = 2'd1;
        if (term == 2'd0) begin
          op_a = kk[inc3(row)][inc3(col)];
          op_b = kk[dec3(row)][dec3(col)];
        end else begin
          op_a = kk[inc3(row)][dec3(col)];
          op_b = kk[dec3(row)][inc3(col)];
        end
      end
      S_DET: begin
        last_term = LAST_IDX;
        op_a = kk[0][term];
        op_b = cof[0][term];
      end
      S_ADJ: begin
        op_a = cof[col][row];
        op_b = inv_reg;
      end
      S_MAC: begin
        last_term = LAST_IDX;
        op_a = wk[row][term];
        op_b = grp[term];
      end
      S_IDLE, S_OUT: begin
        compute = 1'b0;
      end
      default: begin
        compute = 1'b0;
      end
    endcase
    ctl.mul = compute && (phase == PH_MUL);
    ctl.acc = compute && (phase == PH_ACC);
    ctl.clr = (term == 2'd0);
    ctl.sub = (state == S_COF) && (term == 2'd1);
  end

  hill3_mac u_mac (
    .clk  (clk),
    .ctl  (ctl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase        <= PH_MUL;
      row          <= 2'd0;
      col          <= 2'd0;
      term         <= 2'd0;
      key_matrix   <= '0;
      decrypt_mode <= 1'b0;
      fill_count   <= 2'd0;
      key_ready    <= 1'b0;
      key_bad      <= 1'b0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_KEY_MATRIX:   key_matrix <= cfg_data;
          REG_DECRYPT_MODE: decrypt_mode <= cfg_data[0];
          default:          key_matrix <= key_matrix;
        endcase
        key_ready <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            if (fill_count != LAST_IDX && !s_tlast) begin
              held[fill_count[0]] <= letter;
              fill_count <= 2'(fill_count + 2'd1);
            end else begin
              grp[0] <= (fill_count == 2'd0) ? letter : held[0];
              grp[1] <= (fill_count == 2'd0) ? PAD_LETTER :
                        (fill_count == 2'd1) ? letter : held[1];
              grp[2] <= (fill_count == LAST_IDX) ? letter : PAD_LETTER;
              fill_count <= 2'd0;
              row   <= 2'd0;
              col   <= 2'd0;
              term  <= 2'd0;
              phase <= PH_MUL;
              if (key_ready) begin
                state <= S_MAC;
              end else if (decrypt_mode) begin
                state <= S_COF;
              end else begin
                wk        <= kk;
                key_bad   <= 1'b0;
                key_ready <= 1'b1;
                state     <= S_MAC;
              end
            end
          end
        end
        S_OUT: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (row == LAST_IDX) begin
              row   <= 2'd0;
              state <= S_IDLE;
            end else begin
              row   <= 2'(row + 2'd1);
              state <= S_MAC;
            end
          end
        end
        S_COF, S_DET, S_ADJ, S_MAC: begin
          unique case (phase)
            PH_MUL: begin
              phase <= PH_ACC;
            end
            PH_ACC: begin
              if (term == last_term) begin
                phase <= PH_STORE;
              end else begin
                term  <= 2'(term + 2'd1);
                phase <= PH_MUL;
              end
            end
            PH_STORE: begin
              term  <= 2'd0;
              phase <= PH_MUL;
              priority if (state == S_COF) begin
                cof[row][col] <= acc;
                if (col == LAST_IDX) begin
                  col <= 2'd0;
                  if (row == LAST_IDX) begin
                    row   <= 2'd0;
                    state <= S_DET;
                  end else begin
                    row <= 2'(row + 2'd1);
                  end
                end else begin
                  col <= 2'(col + 2'd1);
                end
              end else if (state == S_DET) begin
                row <= 2'd0;
                col <= 2'd0;
                if (det_inv == '0) begin
                  key_bad   <= 1'b1;
                  key_ready <= 1'b1;
                  state     <= S_MAC;
                end else begin
                  inv_reg <= det_inv;
                  state   <= S_ADJ;
                end
              end else if (state == S_ADJ) begin
                wk[row][col] <= acc;
                if (col == LAST_IDX) begin
                  col <= 2'd0;
                  if (row == LAST_IDX) begin
                    row       <= 2'd0;
                    key_bad   <= 1'b0;
                    key_ready <= 1'b1;
                    state     <= S_MAC;
                  end else begin
                    row <= 2'(row + 2'd1);
                  end
                end else begin
                  col <= 2'(col + 2'd1);
                end
              end else begin
                out_letter <= key_bad ? letter_t'(0) : acc;
                out_last   <= (row == LAST_IDX);
                out_bad    <= key_bad;
                m_tvalid   <= 1'b1;
                state      <= S_OUT;
              end
            end
            default: begin
              phase <= PH_MUL;
            end
          endcase
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
